[hw/rtl/assert_macros.svh]
// assertion macros shared by the vector normalize rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define VN3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define VN3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/vn3_pkg.sv]
// shared types for the vector normalize pipeline
package vn3_pkg;

  // pipeline control handed to every cell
  typedef struct packed {
    logic adv;
    logic vld;
  } vn3_ctl_t;

  localparam int unsigned LANES = 3;

endpackage

[hw/rtl/vn3_if.sv]
// request channel interfaces for the vector normalize block
interface vn3_in_if #(parameter int CW = 32);
  logic          valid;
  logic          ready;
  logic [CW-1:0] origin_x;
  logic [CW-1:0] origin_y;
  logic [CW-1:0] origin_z;
  logic [CW-1:0] dest_x;
  logic [CW-1:0] dest_y;
  logic [CW-1:0] dest_z;
  modport source (output valid, origin_x, origin_y, origin_z, dest_x, dest_y, dest_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dest_x, dest_y, dest_z,
                output ready);
endinterface

interface vn3_out_if #(parameter int CW = 32);
  logic          valid;
  logic          ready;
  logic [CW-1:0] new_dest_x;
  logic [CW-1:0] new_dest_y;
  logic [CW-1:0] new_dest_z;
  logic [CW:0]   vec_length;
  logic          normalized;
  modport source (output valid, new_dest_x, new_dest_y, new_dest_z, vec_length, normalized,
                  input ready);
  modport sink (input valid, new_dest_x, new_dest_y, new_dest_z, vec_length, normalized,
                output ready);
endinterface

[hw/rtl/vector_normalize_3d.sv]
// Normalizes the direction from origin to destination and returns origin plus the
// unit direction, saturated, with the floor length and a flag; a request whose length
// is not above min_length returns the destination unchanged with the flag clear.
// Takes one request per clock while input ready is high and returns one result per
// request, in order. The pipeline has four front stages (input register, difference
// and magnitude, squares, sum), one square root cell per root bit, a compare stage
// against min_length, one divide cell per quotient bit working on all three axes at
// once, and the output stage. A two-entry output buffer keeps the pipeline flowing
// while a result waits; input ready drops only when both are full.
// The user must write min_length through cfg_wr_en / cfg_wr_data while the block is idle (not enforced).
`include "assert_macros.svh"
module vector_normalize_3d import vn3_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  vn3_in_if.sink        in_if,
  vn3_out_if.source     out_if,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int M   = CW + 1;
  localparam int SW  = 2 * M;
  localparam int R   = M + 2;
  localparam int QW  = FRAC_BITS + 1;
  localparam int PWS = 6 * CW + 3 * M + 3;
  localparam int PWD = 6 * CW + 4;
  localparam int OW  = 3 * CW + M + 1;

  typedef logic [LANES-1:0][CW-1:0] coord3_t;
  typedef logic [LANES-1:0][M-1:0]  mag3_t;

  logic        adv;
  vn3_ctl_t    ctl;
  logic [15:0] min_len_r;

  // output buffer
  logic          out_vld_r, skid_vld_r;
  logic [OW-1:0] out_r, skid_r;

  assign adv = !skid_vld_r;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
    end else if (cfg_wr_en) begin
      min_len_r <= cfg_wr_data;
    end
  end

  // front stages
  logic    s0_vld_r, s1_vld_r, s2_vld_r, s3_vld_r;
  coord3_t s0_org_r, s0_dst_r, s1_org_r, s1_dst_r, s2_org_r, s2_dst_r, s3_org_r, s3_dst_r;
  mag3_t   s1_mag_r, s2_mag_r, s3_mag_r;
  logic [LANES-1:0] s1_neg_r, s2_neg_r, s3_neg_r;
  logic [LANES-1:0][SW-1:0] s2_sq_r;
  logic [SW-1:0] s3_sum_r;
  mag3_t   s1_mag_nxt;
  logic [LANES-1:0] s1_neg_nxt;
  logic [LANES-1:0][SW-1:0] s2_sq_nxt;

  always_comb begin
    logic [M-1:0] d;
    for (int l = 0; l < LANES; l++) begin
      d = {s0_dst_r[l][CW-1], s0_dst_r[l]} - {s0_org_r[l][CW-1], s0_org_r[l]};
      s1_neg_nxt[l] = d[M-1];
      s1_mag_nxt[l] = d[M-1] ? (~d + 1'b1) : d;
      s2_sq_nxt[l]  = s1_mag_r[l] * s1_mag_r[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_if.valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_org_r <= {in_if.origin_z, in_if.origin_y, in_if.origin_x};
      s0_dst_r <= {in_if.dest_z, in_if.dest_y, in_if.dest_x};
      s1_org_r <= s0_org_r;
      s1_dst_r <= s0_dst_r;
      s1_mag_r <= s1_mag_nxt;
      s1_neg_r <= s1_neg_nxt;
      s2_org_r <= s1_org_r;
      s2_dst_r <= s1_dst_r;
      s2_mag_r <= s1_mag_r;
      s2_neg_r <= s1_neg_r;
      s2_sq_r  <= s2_sq_nxt;
      s3_org_r <= s2_org_r;
      s3_dst_r <= s2_dst_r;
      s3_mag_r <= s2_mag_r;
      s3_neg_r <= s2_neg_r;
      s3_sum_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  // square root chain
  logic           sq_vld  [M+1];
  logic [SW-1:0]  sq_sum  [M+1];
  logic [R-1:0]   sq_rem  [M+1];
  logic [M-1:0]   sq_root [M+1];
  logic [PWS-1:0] sq_pass [M+1];

  assign sq_vld[0]  = s3_vld_r;
  assign sq_sum[0]  = s3_sum_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_pass[0] = {s3_org_r, s3_dst_r, s3_mag_r, s3_neg_r};

  for (genvar i = 0; i < M; i++) begin : g_sqrt
    vn3_sqrt_cell #(.M(M), .PW(PWS)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    ('{adv: adv, vld: sq_vld[i]}),
      .sum_i  (sq_sum[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .pass_i (sq_pass[i]),
      .vld_o  (sq_vld[i+1]),
      .sum_o  (sq_sum[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .pass_o (sq_pass[i+1])
    );
  end

  // compare stage
  coord3_t sq_org, sq_dst, nm_org_r, nm_dst_r;
  mag3_t   sq_mag, nm_mag_r;
  logic [LANES-1:0] sq_neg, nm_neg_r;
  logic    nm_vld_r, nm_norm_r;
  logic [M-1:0] nm_len_r;

  assign {sq_org, sq_dst, sq_mag, sq_neg} = sq_pass[M];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else if (adv) begin
      nm_vld_r <= sq_vld[M];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_org_r  <= sq_org;
      nm_dst_r  <= sq_dst;
      nm_mag_r  <= sq_mag;
      nm_neg_r  <= sq_neg;
      nm_len_r  <= sq_root[M];
      nm_norm_r <= (sq_root[M] > M'(min_len_r));
    end
  end

  // divide chain
  logic                     dv_vld  [QW+1];
  logic [LANES-1:0][M:0]    dv_rem  [QW+1];
  logic [LANES-1:0][QW-1:0] dv_q    [QW+1];
  logic [M-1:0]             dv_len  [QW+1];
  logic [PWD-1:0]           dv_pass [QW+1];

  assign dv_vld[0]  = nm_vld_r;
  assign dv_len[0]  = nm_len_r;
  assign dv_q[0]    = '0;
  assign dv_pass[0] = {nm_org_r, nm_dst_r, nm_neg_r, nm_norm_r};
  for (genvar l = 0; l < LANES; l++) begin : g_rem0
    assign dv_rem[0][l] = {1'b0, nm_mag_r[l]};
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    vn3_div_cell #(.M(M), .QW(QW), .PW(PWD)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    ('{adv: adv, vld: dv_vld[i]}),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .len_i  (dv_len[i]),
      .pass_i (dv_pass[i]),
      .vld_o  (dv_vld[i+1]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1]),
      .len_o  (dv_len[i+1]),
      .pass_o (dv_pass[i+1])
    );
  end

  // add to origin and saturate, or pass the destination through when not normalized
  coord3_t dv_org, dv_dst, fin_xyz;
  logic [LANES-1:0] dv_neg;
  logic    dv_norm;
  logic [OW-1:0] fin;

  assign {dv_org, dv_dst, dv_neg, dv_norm} = dv_pass[QW];

  always_comb begin
    logic [M-1:0] u;
    logic [M-1:0] s;
    for (int l = 0; l < LANES; l++) begin
      u = M'(dv_q[QW][l]);
      s = {dv_org[l][CW-1], dv_org[l]} + (dv_neg[l] ? (~u + 1'b1) : u);
      if (!dv_norm) begin
        fin_xyz[l] = dv_dst[l];
      end else if (s[M-1] != s[M-2]) begin
        fin_xyz[l] = s[M-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
        fin_xyz[l] = s[CW-1:0];
      end
    end
  end

  assign fin = {fin_xyz, dv_len[QW], dv_norm};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && out_if.ready) begin
      if (skid_vld_r) begin
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= dv_vld[QW];
      end
    end else if (!out_vld_r) begin
      out_vld_r <= dv_vld[QW] && adv;
    end else if (adv) begin
      skid_vld_r <= dv_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && out_if.ready) begin
      out_r <= skid_vld_r ? skid_r : fin;
    end else if (!out_vld_r) begin
      out_r <= fin;
    end
    if (adv) begin
      skid_r <= fin;
    end
  end

  assign out_if.valid = out_vld_r;
  assign {out_if.new_dest_z, out_if.new_dest_y, out_if.new_dest_x,
          out_if.vec_length, out_if.normalized} = out_r;

  `VN3_ASSERT(a_skid_needs_out, skid_vld_r |-> out_vld_r, "buffer entry without head result")
  `VN3_ASSERT(a_stall_when_full, !in_if.ready |-> skid_vld_r && out_vld_r, "input stalled with room left")
  `VN3_ASSERT(a_norm_len, out_vld_r && out_r[0] |-> out_r[M:1] > M'(min_len_r), "normalized at or below minimum length")

endmodule

[hw/rtl/vn3_sqrt_cell.sv]
// one root bit of the digit-by-digit square root chain
`include "assert_macros.svh"
module vn3_sqrt_cell import vn3_pkg::*; #(
  parameter int M  = 33,
  parameter int PW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  vn3_ctl_t       ctl,
  input  logic [2*M-1:0] sum_i,
  input  logic [M+1:0]   rem_i,
  input  logic [M-1:0]   root_i,
  input  logic [PW-1:0]  pass_i,
  output logic           vld_o,
  output logic [2*M-1:0] sum_o,
  output logic [M+1:0]   rem_o,
  output logic [M-1:0]   root_o,
  output logic [PW-1:0]  pass_o
);

  logic           vld_r;
  logic [2*M-1:0] sum_r, sum_nxt;
  logic [M+1:0]   rem_r, rem_nxt;
  logic [M-1:0]   root_r, root_nxt;
  logic [PW-1:0]  pass_r;
  logic [M+1:0]   remx;
  logic [M+1:0]   trial;
  logic           ge;

  // bring down the next two bits of the radicand
  assign remx     = {rem_i[M-1:0], sum_i[2*M-1 -: 2]};
  assign trial    = {root_i, 2'b01};
  assign ge       = (remx >= trial);
  assign rem_nxt  = ge ? (remx - trial) : remx;
  assign root_nxt = {root_i[M-2:0], ge};
  assign sum_nxt  = {sum_i[2*M-3:0], 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sum_r  <= sum_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      pass_r <= pass_i;
    end
  end

  assign vld_o  = vld_r;
  assign sum_o  = sum_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign pass_o = pass_r;

  // partial remainder never exceeds twice the partial root
  `VN3_ASSERT(a_rem_bound, ctl.adv && ctl.vld |=> rem_r <= {1'b0, root_r, 1'b0}, "sqrt remainder out of range")

endmodule

[hw/rtl/vn3_div_cell.sv]
// one quotient bit of the three-lane restoring divide chain
module vn3_div_cell import vn3_pkg::*; #(
  parameter int M  = 33,
  parameter int QW = 17,
  parameter int PW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vn3_ctl_t                    ctl,
  input  logic [LANES-1:0][M:0]       rem_i,
  input  logic [LANES-1:0][QW-1:0]    q_i,
  input  logic [M-1:0]                len_i,
  input  logic [PW-1:0]               pass_i,
  output logic                        vld_o,
  output logic [LANES-1:0][M:0]       rem_o,
  output logic [LANES-1:0][QW-1:0]    q_o,
  output logic [M-1:0]                len_o,
  output logic [PW-1:0]               pass_o
);

  logic                     vld_r;
  logic [LANES-1:0][M:0]    rem_r, rem_nxt;
  logic [LANES-1:0][QW-1:0] q_r, q_nxt;
  logic [M-1:0]             len_r;
  logic [PW-1:0]            pass_r;

  always_comb begin
    logic         ge;
    logic [M:0]   t;
    for (int l = 0; l < LANES; l++) begin
      ge = (rem_i[l] >= {1'b0, len_i});
      t  = ge ? (rem_i[l] - {1'b0, len_i}) : rem_i[l];
      rem_nxt[l] = {t[M-1:0], 1'b0};
      q_nxt[l]   = {q_i[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      len_r  <= len_i;
      pass_r <= pass_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign len_o  = len_r;
  assign pass_o = pass_r;

endmodule
